/* hw/rtl/kmer_min_hamming_distance_sum_macros.svh */
// Assertion macros for the k-mer minimum Hamming distance block.
// Used by the top level. Every macro expects i_clk and i_rst_n in scope.
`ifndef KMER_MIN_HAMMING_DISTANCE_SUM_MACROS_SVH
`define KMER_MIN_HAMMING_DISTANCE_SUM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMHD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KMHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/kmhd_pkg.sv */
// Shared constants, types and helpers for the k-mer minimum Hamming distance block.
// No dependencies.
package kmhd_pkg;

    localparam int MAX_PATTERN_LEN = 16;
    localparam int TOTAL_WIDTH     = 16;
    localparam int WIN_W           = 2 * MAX_PATTERN_LEN;
    localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PLEN_REG_W      = 5;
    localparam int QUEUE_DEPTH     = 4;
    localparam int PTR_W           = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BASES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

    localparam logic [PLEN_REG_W-1:0] PLEN_RESET = PLEN_REG_W'(6);

    // One finished text as handed from the front to the back.
    typedef struct packed {
        logic [LEN_W-1:0] min_dist;
        logic             short_text;
        logic             set_done;
    } t_text_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Pattern length as used: zero acts as one, large values clamp to the window size.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [PLEN_REG_W-1:0] len);
        logic [LEN_W-1:0] k;
        if (len == '0) begin
            k = LEN_W'(1);
        end else if (32'(len) > MAX_PATTERN_LEN) begin
            k = LEN_W'(MAX_PATTERN_LEN);
        end else begin
            k = LEN_W'(len);
        end
        return k;
    endfunction

endpackage

/* hw/rtl/kmhd_front.sv */
// Front end: holds the pattern registers, shifts bases into the window and tracks
// the per-text minimum distance. Depends on kmhd_pkg.
module kmhd_front import kmhd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_base,
    input  logic                  i_eot,
    input  logic                  i_eos,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_full,
    output logic                  o_push,
    output t_text_result          o_entry
);

    logic [WIN_W-1:0]      r_pattern;
    logic [PLEN_REG_W-1:0] r_plen;
    logic [WIN_W-1:0]      r_win;
    logic [LEN_W-1:0]      r_fill;
    logic [LEN_W-1:0]      r_min;

    logic [WIN_W-1:0]      n_win;
    logic [LEN_W-1:0]      n_fill;
    logic [LEN_W-1:0]      k;
    logic [LEN_W-1:0]      shamt;
    logic [WIN_W-1:0]      win_al;
    logic [WIN_W-1:0]      diff;
    logic [LEN_W-1:0]      lane_miss;
    logic                  full_win;
    logic [LEN_W-1:0]      cand;
    logic                  accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign k      = clamp_len(r_plen);
    assign n_win  = {i_base, r_win[WIN_W-1:2]};
    assign n_fill = (32'(r_fill) < MAX_PATTERN_LEN) ? r_fill + 1'b1 : r_fill;
    assign shamt  = LEN_W'(MAX_PATTERN_LEN) - k;

    // The newest k bases sit at the top of the window; bring them down to line up
    // with the pattern and count the lanes that differ.
    always_comb begin
        win_al    = n_win >> {shamt, 1'b0};
        diff      = win_al ^ r_pattern;
        lane_miss = '0;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if ((LEN_W'(i) < k) && (diff[2*i] || diff[2*i+1])) begin
                lane_miss = lane_miss + 1'b1;
            end
        end
    end

    assign full_win = (n_fill >= k);
    assign cand     = (full_win && (lane_miss < r_min)) ? lane_miss : r_min;

    assign o_push             = accept && i_eot;
    assign o_entry.min_dist   = full_win ? cand : '0;
    assign o_entry.short_text = !full_win;
    assign o_entry.set_done   = i_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= PLEN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PATTERN_BASES) begin
                r_pattern <= WIN_W'(i_cfg_data);
            end else if (i_cfg_index == CFG_PATTERN_LENGTH) begin
                r_plen <= i_cfg_data[PLEN_REG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
            r_min  <= '1;
        end else if (accept) begin
            if (i_eot) begin
                r_win  <= '0;
                r_fill <= '0;
                r_min  <= '1;
            end else begin
                r_win  <= n_win;
                r_fill <= n_fill;
                r_min  <= cand;
            end
        end
    end

endmodule

/* hw/rtl/kmhd_queue.sv */
// Short queue of finished text results between the front and the back end.
// Depends on kmhd_pkg.
module kmhd_queue import kmhd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_text_result  i_entry,
    input  logic          i_pop,
    output t_text_result  o_head,
    output t_queue_status o_status
);

    t_text_result     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (32'(r_count) == QUEUE_DEPTH);
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/kmhd_back.sv */
// Back end: adds each text minimum into the saturating set total and holds the
// result beat until it is taken. Depends on kmhd_pkg.
module kmhd_back import kmhd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_text_result           i_head,
    input  t_queue_status          i_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [LEN_W-1:0]       o_dist,
    output logic [TOTAL_WIDTH-1:0] o_total,
    output logic                   o_short,
    output logic                   o_done
);

    logic [TOTAL_WIDTH-1:0] r_sum;
    logic                   r_valid;
    logic [LEN_W-1:0]       r_dist;
    logic [TOTAL_WIDTH-1:0] r_total;
    logic                   r_short;
    logic                   r_done;

    logic [TOTAL_WIDTH:0]   sum_wide;
    logic [TOTAL_WIDTH-1:0] sum_sat;
    logic [TOTAL_WIDTH-1:0] n_total;

    assign o_pop = !i_status.empty && (!r_valid || i_ready);

    assign sum_wide = {1'b0, r_sum} + (TOTAL_WIDTH + 1)'(i_head.min_dist);
    assign sum_sat  = sum_wide[TOTAL_WIDTH] ? '1 : sum_wide[TOTAL_WIDTH-1:0];
    assign n_total  = i_head.short_text ? r_sum : sum_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_sum   <= i_head.set_done ? '0 : n_total;
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dist  <= i_head.min_dist;
            r_total <= n_total;
            r_short <= i_head.short_text;
            r_done  <= i_head.set_done;
        end
    end

    assign o_valid = r_valid;
    assign o_dist  = r_dist;
    assign o_total = r_total;
    assign o_short = r_short;
    assign o_done  = r_done;

endmodule

/* hw/rtl/kmer_min_hamming_distance_sum.sv */
// Top level of the k-mer minimum Hamming distance block.
// Depends on kmhd_pkg, kmhd_front, kmhd_queue, kmhd_back and the assertion macros.

// The block takes one DNA base per beat (tdata[1:0]: 0 A, 1 G, 2 T, 3 C), with
// tlast on the last base of a text and tuser on that base when the text ends the
// set. It keeps the last bases in a window and, once k bases of the text have
// arrived, compares the newest k with the configured pattern each beat, keeping
// the least mismatch count. At the end of each text it sends one beat: the text
// minimum and the saturating set total, tuser set for a text shorter than k
// (which reports 0 and adds nothing), tlast on the final text of the set, after
// which the total restarts at zero. One base is taken every clock cycle while
// the queue has room; the window compare, lane mismatch count and minimum
// update of a base finish within that cycle. Text results pass through a
// four-entry queue and an output register; the input stalls whenever the queue
// holds four results, whatever the output register holds.
// Configuration writes are always ready and take effect on the next base.
`include "kmer_min_hamming_distance_sum_macros.svh"

module kmer_min_hamming_distance_sum import kmhd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [1:0] base, rest zero
    input  logic                  s_axis_tlast,
    input  logic                  s_axis_tuser,   // [0] end_of_set
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [4:0] text_min_distance,
                                                  // [20:5] set_total, rest zero
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser,   // [0] short_text
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_text_result           push_entry;
    t_text_result           head_entry;
    t_queue_status          q_status;
    logic                   push;
    logic                   pop;
    logic [LEN_W-1:0]       out_dist;
    logic [TOTAL_WIDTH-1:0] out_total;

    assign o_cfg_ready = 1'b1;

    kmhd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_base      (s_axis_tdata[1:0]),
        .i_eot       (s_axis_tlast),
        .i_eos       (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (q_status.full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    kmhd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    kmhd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_entry),
        .i_status (q_status),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_dist   (out_dist),
        .o_total  (out_total),
        .o_short  (m_axis_tuser),
        .o_done   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_total, out_dist};

    // A short text never carries a distance.
    `KMHD_ASSERT_SAME(a_short_zero, m_axis_tvalid && m_axis_tuser, out_dist == '0, "short dist")

    // A reported minimum never exceeds the window size.
    `KMHD_ASSERT_SAME(a_dist_range, m_axis_tvalid, 32'(out_dist) <= MAX_PATTERN_LEN, "dist range")

    // The input is held off exactly while the queue is full, and a full queue is not empty.
    `KMHD_ASSERT_SAME(a_full_stall, q_status.full, !s_axis_tready && !q_status.empty, "q status")

    // A result is only pushed while the queue has room, so it leaves a nonempty queue.
    `KMHD_ASSERT_NEXT(a_push_lands, push && !pop, !q_status.empty, "pushed result lost")

endmodule
